// ===== rtl/tun_pkg.sv =====
// Shared constants for the triangle unit normal block.
package tun_pkg;

   // Register map: the register index is byte address bit 2
   localparam int  CSR_ADDR_W          = 3;
   localparam logic REG_ZERO_THRESHOLD = 1'b0;

   localparam logic [15:0] ZERO_THRESHOLD_RESET = 16'd128;

   // |n|^2 at or below this marks the triangle degenerate
   localparam int unsigned DEGEN_SQ = 4;

endpackage

// ===== rtl/triangle_unit_normal.sv =====
// Triangle unit normal: edges, cross product, exact rounded normalization.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+---------------------------------
//  request  | req_a_x .. req_c_z (signed Q12.12)      | beat taken when start && !busy
//  response | rsp_normal_x/y/z (Q1.F), rsp_degenerate | one-cycle beat marked by rsp_valid
//  config   | psel penable pwrite paddr pwdata prdata | APB write on access phase
//
// One triangle per clock; busy is never raised. The pipe has seven front stages
// (edges, products, cross, partial squares, squares, magnitude sum, search setup),
// one digit stage per magnitude bit (F+1), and the output register. The digit stages
// set the depth.
// Reset is synchronous, clears the valid bits and loads the threshold with 128.
// The receiver cannot stall, so nothing in the pipe ever holds.
module triangle_unit_normal
   import tun_pkg::*;
#(
   parameter int COORD_BITS    = 24,
   parameter int OUT_FRAC_BITS = 30
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic signed [COORD_BITS-1:0]    req_a_x,
   input  logic signed [COORD_BITS-1:0]    req_a_y,
   input  logic signed [COORD_BITS-1:0]    req_a_z,
   input  logic signed [COORD_BITS-1:0]    req_b_x,
   input  logic signed [COORD_BITS-1:0]    req_b_y,
   input  logic signed [COORD_BITS-1:0]    req_b_z,
   input  logic signed [COORD_BITS-1:0]    req_c_x,
   input  logic signed [COORD_BITS-1:0]    req_c_y,
   input  logic signed [COORD_BITS-1:0]    req_c_z,
   output logic                            rsp_valid,
   output logic signed [OUT_FRAC_BITS+1:0] rsp_normal_x,
   output logic signed [OUT_FRAC_BITS+1:0] rsp_normal_y,
   output logic signed [OUT_FRAC_BITS+1:0] rsp_normal_z,
   output logic                            rsp_degenerate,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [CSR_ADDR_W-1:0]           paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   localparam int CB  = COORD_BITS;
   localparam int F   = OUT_FRAC_BITS;
   localparam int EW  = CB + 1;          // edge component, signed
   localparam int PRW = 2 * CB + 2;      // edge product, signed
   localparam int NW  = 2 * CB + 3;      // cross component, signed
   localparam int CMW = 2 * CB + 2;      // cross magnitude
   localparam int HB  = (CMW + 1) / 2;   // low half for split squaring, high half fits too
   localparam int SW  = 2 * CMW;         // square and sum of squares
   localparam int PW  = SW + F + 3;      // running t*s term
   localparam int EWS = PW + F + 4;      // remainder, two's complement
   localparam int KW  = F + 1;           // rounded magnitude
   localparam int OW  = F + 2;           // output component
   localparam int CW  = (KW > 16) ? KW : 16;

   // ---------------- configuration ----------------
   logic [15:0] thr_ff, thr_in;
   logic        csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;
   assign thr_in = (csr_wr && paddr[2] == REG_ZERO_THRESHOLD) ? pwdata[15:0] : thr_ff;
   assign prdata = (paddr[2] == REG_ZERO_THRESHOLD) ? {16'd0, thr_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= ZERO_THRESHOLD_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   assign busy = 1'b0;

   logic accept;
   assign accept = start && !busy;

   // ---------------- stage 1: edge vectors ----------------
   logic signed [CB-1:0] va [3], vb [3], vc [3];
   assign va = '{req_a_x, req_a_y, req_a_z};
   assign vb = '{req_b_x, req_b_y, req_b_z};
   assign vc = '{req_c_x, req_c_y, req_c_z};

   logic                 v1_ff;
   logic signed [EW-1:0] e1_ff [3], e2_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         e1_ff[i] <= EW'(va[i]) - EW'(vb[i]);
         e2_ff[i] <= EW'(vb[i]) - EW'(vc[i]);
      end
   end

   // ---------------- stage 2: edge products, two per cross component ----------------
   logic signed [PRW-1:0] x1 [3], x2 [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         x1[i] = PRW'(e1_ff[i]);
         x2[i] = PRW'(e2_ff[i]);
      end
   end

   logic                  v2_ff;
   logic signed [PRW-1:0] p_ff [6];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      p_ff[0] <= x1[1] * x2[2];
      p_ff[1] <= x1[2] * x2[1];
      p_ff[2] <= x1[2] * x2[0];
      p_ff[3] <= x1[0] * x2[2];
      p_ff[4] <= x1[0] * x2[1];
      p_ff[5] <= x1[1] * x2[0];
   end

   // ---------------- stage 3: cross product, sign and magnitude ----------------
   logic signed [NW-1:0] nc [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nc[i] = NW'(p_ff[2*i]) - NW'(p_ff[2*i+1]);
      end
   end

   logic           v3_ff;
   logic           neg3_ff [3];
   logic [CMW-1:0] mag3_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         neg3_ff[i] <= nc[i][NW-1];
         mag3_ff[i] <= nc[i][NW-1] ? CMW'(-nc[i]) : CMW'(nc[i]);
      end
   end

   // ---------------- stage 4: partial products of the squares ----------------
   logic              v4_ff;
   logic              neg4_ff [3];
   logic [2*HB-1:0]   hh_ff [3], hl_ff [3], ll_ff [3];
   logic [HB-1:0]     lo4 [3];
   logic [HB-1:0]     hi4 [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lo4[i] = mag3_ff[i][HB-1:0];
         hi4[i] = HB'(mag3_ff[i][CMW-1:HB]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         neg4_ff[i] <= neg3_ff[i];
         hh_ff[i]   <= (2*HB)'(hi4[i]) * (2*HB)'(hi4[i]);
         hl_ff[i]   <= (2*HB)'(hi4[i]) * (2*HB)'(lo4[i]);
         ll_ff[i]   <= (2*HB)'(lo4[i]) * (2*HB)'(lo4[i]);
      end
   end

   // ---------------- stage 5: squares of the cross components ----------------
   logic          v5_ff;
   logic          neg5_ff [3];
   logic [SW-1:0] sq5_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         neg5_ff[i] <= neg4_ff[i];
         sq5_ff[i]  <= (SW'(hh_ff[i]) << (2*HB)) + (SW'(hl_ff[i]) << (HB+1))
                     + SW'(ll_ff[i]);
      end
   end

   // ---------------- stage 6: |n|^2 and degenerate test ----------------
   logic          v6_ff, dg6_ff;
   logic          neg6_ff [3];
   logic [SW-1:0] sq6_ff [3];
   logic [SW-1:0] s6_ff;
   logic [SW-1:0] s6_in;

   assign s6_in = sq5_ff[0] + sq5_ff[1] + sq5_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      s6_ff  <= s6_in;
      dg6_ff <= (s6_in <= SW'(DEGEN_SQ));
      for (int i = 0; i < 3; i++) begin
         neg6_ff[i] <= neg5_ff[i];
         sq6_ff[i]  <= sq5_ff[i];
      end
   end

   // ---------------- stage 7: search setup ----------------
   // Digit search finds the largest m with (2m-1)^2 * s <= 4 * n^2 * 2^(2F).
   // E holds the remainder 4 n^2 2^(2F) - t^2 s and P holds t*s, t = 2m-1;
   // both start from m = 0 (t = -1). Values are two's complement.
   logic          sv_ff  [F+2];
   logic          sd_ff  [F+2];
   logic [SW-1:0] ss_ff  [F+2];
   logic          sn_ff  [F+2][3];
   logic [EWS-1:0] se_ff [F+2][3];
   logic [PW-1:0]  sp_ff [F+2][3];
   logic [KW-1:0]  sm_ff [F+2][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff[0] <= 1'b0;
      end else begin
         sv_ff[0] <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      sd_ff[0] <= dg6_ff;
      ss_ff[0] <= s6_ff;
      for (int i = 0; i < 3; i++) begin
         sn_ff[0][i] <= neg6_ff[i];
         se_ff[0][i] <= (EWS'(sq6_ff[i]) << (2*F+2)) - EWS'(s6_ff);
         sp_ff[0][i] <= PW'(0) - PW'(s6_ff);
         sm_ff[0][i] <= '0;
      end
   end

   // ---------------- digit stages, MSB first ----------------
   // Trying bit d of m: t grows by 2d, so t^2 s grows by 4d(P + d s).
   for (genvar g = 0; g <= F; g++) begin : g_digit
      localparam int J = F - g;

      logic [PW-1:0]  dt [3];
      logic [EWS-1:0] et [3];

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            dt[i] = sp_ff[g][i] + (PW'(ss_ff[g]) << J);
            et[i] = se_ff[g][i] - (EWS'(dt[i]) << (J + 2));
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[g+1] <= 1'b0;
         end else begin
            sv_ff[g+1] <= sv_ff[g];
         end
      end

      always_ff @(posedge clock) begin
         sd_ff[g+1] <= sd_ff[g];
         ss_ff[g+1] <= ss_ff[g];
         for (int i = 0; i < 3; i++) begin
            sn_ff[g+1][i] <= sn_ff[g][i];
            if (!et[i][EWS-1]) begin
               se_ff[g+1][i] <= et[i];
               sp_ff[g+1][i] <= sp_ff[g][i] + (PW'(ss_ff[g]) << (J + 1));
               sm_ff[g+1][i] <= sm_ff[g][i] | (KW'(1) << J);
            end else begin
               se_ff[g+1][i] <= se_ff[g][i];
               sp_ff[g+1][i] <= sp_ff[g][i];
               sm_ff[g+1][i] <= sm_ff[g][i];
            end
         end
      end
   end

   // ---------------- output register ----------------
   logic          rv_ff, rd_ff;
   logic [OW-1:0] rn_ff [3];
   logic [OW-1:0] rn_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (sd_ff[F+1] || (CW'(sm_ff[F+1][i]) < CW'(thr_ff))) begin
            rn_in[i] = '0;
         end else if (sn_ff[F+1][i]) begin
            rn_in[i] = OW'(0) - OW'(sm_ff[F+1][i]);
         end else begin
            rn_in[i] = OW'(sm_ff[F+1][i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= sv_ff[F+1];
      end
   end

   always_ff @(posedge clock) begin
      if (sv_ff[F+1]) begin
         rd_ff <= sd_ff[F+1];
         for (int i = 0; i < 3; i++) begin
            rn_ff[i] <= rn_in[i];
         end
      end
   end

   assign rsp_valid      = rv_ff;
   assign rsp_degenerate = rd_ff;
   assign rsp_normal_x   = $signed(rn_ff[0]);
   assign rsp_normal_y   = $signed(rn_ff[1]);
   assign rsp_normal_z   = $signed(rn_ff[2]);

endmodule

// ===== rtl/tun_chk.sv =====
// Port-level checker for the triangle unit normal block, with its bind.
module tun_chk #(
   parameter int OUT_FRAC_BITS = 30
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_valid,
   input logic signed [OUT_FRAC_BITS+1:0] rsp_normal_x,
   input logic signed [OUT_FRAC_BITS+1:0] rsp_normal_y,
   input logic signed [OUT_FRAC_BITS+1:0] rsp_normal_z,
   input logic                            rsp_degenerate
);

   localparam int LAT = OUT_FRAC_BITS + 9;
   localparam int OW  = OUT_FRAC_BITS + 2;
   localparam logic signed [OW-1:0] ONE  = OW'(1) << OUT_FRAC_BITS;
   localparam logic signed [OW-1:0] MONE = -ONE;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LAT rsp_valid)
      else $error("accepted beat did not come out after fixed latency");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("response beat without a matching request");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_normal_x == 0 && rsp_normal_y == 0 && rsp_normal_z == 0)
      else $error("degenerate beat with nonzero normal");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_normal_x <= ONE && rsp_normal_x >= MONE
         && rsp_normal_y <= ONE && rsp_normal_y >= MONE
         && rsp_normal_z <= ONE && rsp_normal_z >= MONE)
      else $error("normal component outside unit range");

endmodule

bind triangle_unit_normal tun_chk #(
   .OUT_FRAC_BITS (OUT_FRAC_BITS)
) u_tun_chk (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_normal_x   (rsp_normal_x),
   .rsp_normal_y   (rsp_normal_y),
   .rsp_normal_z   (rsp_normal_z),
   .rsp_degenerate (rsp_degenerate)
);

// ===== bench/tb_triangle_unit_normal.sv =====
// Testbench for the triangle unit normal block: scoreboard class, drivers, checks.
`timescale 1ns / 100ps

module tb_triangle_unit_normal;
   import tun_pkg::*;

   localparam int CB = 24;
   localparam int OF = 30;
   localparam int LATENCY = OF + 9;

   typedef logic signed [CB-1:0] coord_type;
   typedef logic signed [OF+1:0] comp_type;
   typedef logic [191:0] wide_type;

   // Register byte addresses: register index times four
   localparam logic [CSR_ADDR_W-1:0] ADDR_ZERO_THRESHOLD = CSR_ADDR_W'(REG_ZERO_THRESHOLD) << 2;
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNUSED = CSR_ADDR_W'(4);

   typedef struct packed {
      coord_type ax, ay, az, bx, by, bz, cx, cy, cz;
   } tri_type;

   typedef struct packed {
      comp_type nx, ny, nz;
      logic degen;
   } normal_type;

   // Scoreboard: holds the threshold copy and the queue of predicted normals
   class normal_board;
      normal_type  expected_q[$];
      logic [15:0] threshold;
      int          errors;

      function new();
         threshold = ZERO_THRESHOLD_RESET;
         errors = 0;
      endfunction

      task report(string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         errors++;
      endtask

      // round(|c| * 2^OF / sqrt(s)), exact binary search on odd half-steps
      function longint unsigned unit_mag(longint unsigned c, wide_type s);
         wide_type rhs, m, lhs;
         longint unsigned lo, hi, mid;
         rhs = (wide_type'(c) * wide_type'(c)) << (2 * OF + 2);
         lo = 0;
         hi = (64'd1 << OF) + 1;
         while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            m = wide_type'(2 * mid - 1);
            lhs = m * m * s;
            if (lhs <= rhs) lo = mid;
            else hi = mid;
         end
         return lo;
      endfunction

      function normal_type predict(tri_type t);
         longint e1x, e1y, e1z, e2x, e2y, e2z;
         longint n[3];
         longint unsigned k, mg;
         wide_type s;
         normal_type r;
         e1x = longint'(t.ax) - longint'(t.bx);
         e1y = longint'(t.ay) - longint'(t.by);
         e1z = longint'(t.az) - longint'(t.bz);
         e2x = longint'(t.bx) - longint'(t.cx);
         e2y = longint'(t.by) - longint'(t.cy);
         e2z = longint'(t.bz) - longint'(t.cz);
         n[0] = e1y * e2z - e1z * e2y;
         n[1] = e1z * e2x - e1x * e2z;
         n[2] = e1x * e2y - e1y * e2x;
         s = '0;
         for (int i = 0; i < 3; i++) begin
            mg = n[i] < 0 ? -n[i] : n[i];
            s += wide_type'(mg) * wide_type'(mg);
         end
         r = '0;
         if (s <= wide_type'(DEGEN_SQ)) begin
            r.degen = 1'b1;
            return r;
         end
         for (int i = 0; i < 3; i++) begin
            mg = n[i] < 0 ? -n[i] : n[i];
            k = unit_mag(mg, s);
            if (k < threshold) k = 0;
            if (n[i] < 0) k = -k;
            case (i)
               0: r.nx = comp_type'(k);
               1: r.ny = comp_type'(k);
               default: r.nz = comp_type'(k);
            endcase
         end
         return r;
      endfunction

      function void note(tri_type t);
         expected_q.push_back(predict(t));
      endfunction

      task check(normal_type got);
         normal_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected beat %h", got));
            return;
         end
         want = expected_q.pop_front();
         if (got.nx !== want.nx)
            report($sformatf("normal_x got %0d want %0d", got.nx, want.nx));
         if (got.ny !== want.ny)
            report($sformatf("normal_y got %0d want %0d", got.ny, want.ny));
         if (got.nz !== want.nz)
            report($sformatf("normal_z got %0d want %0d", got.nz, want.nz));
         if (got.degen !== want.degen)
            report($sformatf("degenerate got %b want %b", got.degen, want.degen));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   tri_type drv = '0;
   logic rsp_valid, rsp_degenerate;
   comp_type rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   normal_board board = new();

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   triangle_unit_normal #(.COORD_BITS(CB), .OUT_FRAC_BITS(OF)) u_dut (
      .clock, .reset, .start, .busy,
      .req_a_x(drv.ax), .req_a_y(drv.ay), .req_a_z(drv.az),
      .req_b_x(drv.bx), .req_b_y(drv.by), .req_b_z(drv.bz),
      .req_c_x(drv.cx), .req_c_y(drv.cy), .req_c_z(drv.cz),
      .rsp_valid, .rsp_normal_x, .rsp_normal_y, .rsp_normal_z, .rsp_degenerate,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   // Monitors: a request beat is predicted, a response beat is checked
   always @(posedge clock) begin
      if (!reset && start && !busy) board.note(drv);
      if (!reset && rsp_valid)
         board.check({rsp_normal_x, rsp_normal_y, rsp_normal_z, rsp_degenerate});
   end

   // Sender burst state: items left in the current burst
   int burst_left = 0;

   // Drive one triangle; held until a clock edge takes it
   task send(tri_type t);
      if (burst_left == 0) begin
         // gap between bursts; zero gaps leave back-to-back stretches
         if ($urandom_range(0, 2) != 0) begin
            @(negedge clock);
            start = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      @(negedge clock);
      start = 1'b1;
      drv = t;
      do @(posedge clock); while (busy);
      burst_left--;
   endtask

   // Stop sending, wait for every predicted normal, then let the pipe drain
   task drain();
      @(negedge clock);
      start = 1'b0;
      burst_left = 0;
      while (board.expected_q.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task csr_write(logic [CSR_ADDR_W-1:0] addr, logic [31:0] data);
      @(negedge clock);
      psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == ADDR_ZERO_THRESHOLD) board.threshold = data[15:0];
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
   endtask

   task csr_readback();
      logic [31:0] got;
      @(negedge clock);
      psel = 1'b1; penable = 1'b0; pwrite = 1'b0; paddr = ADDR_ZERO_THRESHOLD;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      @(negedge clock);
      psel = 1'b0; penable = 1'b0;
      if (got[15:0] !== board.threshold)
         board.report($sformatf("zero_threshold read %0d want %0d", got[15:0], board.threshold));
   endtask

   function automatic tri_type tri_from(coord_type ax, coord_type ay, coord_type az,
                                        coord_type bx, coord_type by, coord_type bz,
                                        coord_type cx, coord_type cy, coord_type cz);
      tri_type t;
      t.ax = ax; t.ay = ay; t.az = az;
      t.bx = bx; t.by = by; t.bz = bz;
      t.cx = cx; t.cy = cy; t.cz = cz;
      return t;
   endfunction

   function automatic coord_type near(coord_type base, int spread);
      return base + coord_type'($urandom_range(0, 2 * spread) - spread);
   endfunction

   // Random triangle: several shapes, mostly real triangles with random content
   function automatic tri_type random_tri();
      tri_type t;
      coord_type bx, by, bz;
      int sp, kind;
      logic [2:0] flat;
      kind = $urandom_range(0, 9);
      bx = coord_type'($urandom); by = coord_type'($urandom); bz = coord_type'($urandom);
      sp = 1 << $urandom_range(0, 22);
      case (kind)
         0, 1, 2: t = {coord_type'($urandom), coord_type'($urandom), coord_type'($urandom),
                       coord_type'($urandom), coord_type'($urandom), coord_type'($urandom),
                       coord_type'($urandom), coord_type'($urandom), coord_type'($urandom)};
         3, 4: t = tri_from(near(bx, sp), near(by, sp), near(bz, sp), bx, by, bz,
                            near(bx, sp), near(by, sp), near(bz, sp));
         5: begin
            // nearly flat along one or more axes: tiny components meet the threshold
            flat = 3'($urandom);
            t = tri_from(near(bx, flat[0] ? 2 : sp), near(by, flat[1] ? 2 : sp),
                         near(bz, flat[2] ? 2 : sp), bx, by, bz,
                         near(bx, flat[0] ? 2 : sp), near(by, flat[1] ? 2 : sp),
                         near(bz, flat[2] ? 2 : sp));
         end
         6: t = tri_from(near(bx, 2), near(by, 2), near(bz, 2), bx, by, bz,
                         near(bx, 2), near(by, 2), near(bz, 2));
         7: begin
            // collinear: c continues the line a-b
            t = tri_from(near(bx, 1000), near(by, 1000), near(bz, 1000), bx, by, bz, bx, by, bz);
            t.cx = bx - (t.ax - bx); t.cy = by - (t.ay - by); t.cz = bz - (t.az - bz);
         end
         8: t = tri_from(bx, by, bz, bx, by, bz, coord_type'($urandom), coord_type'($urandom),
                         coord_type'($urandom));
         default: begin
            // extremes mixed in each coordinate
            for (int i = 0; i < 9; i++)
               t[i*CB +: CB] = $urandom_range(0, 1) ? {1'b1, {(CB-1){1'b0}}}
                                                    : {1'b0, {(CB-1){1'b1}}};
         end
      endcase
      return t;
   endfunction

   localparam coord_type CMAX = {1'b0, {(CB-1){1'b1}}};
   localparam coord_type CMIN = {1'b1, {(CB-1){1'b0}}};
   localparam coord_type ONE = coord_type'(4096);

   initial begin
      logic [15:0] thresholds [5];
      thresholds = '{16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd128};
      thresholds[3] = 16'($urandom_range(2, 4000));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed triangles at the reset threshold
      send(tri_from(0, 0, 0, 0, 0, 0, 0, 0, 0));                  // all points equal
      send(tri_from(ONE, 0, 0, 0, 0, 0, 0, ONE, 0));              // xy plane, exact unit z
      send(tri_from(0, ONE, 0, 0, 0, 0, 0, 0, ONE));              // exact unit x
      send(tri_from(0, 0, ONE, 0, 0, 0, ONE, 0, 0));              // exact unit y
      send(tri_from(1, 0, 0, 0, 0, 0, 0, 1, 0));                  // smallest nonzero
      send(tri_from(2, 0, 0, 0, 0, 0, 0, 1, 0));                  // magnitude sum 4
      send(tri_from(1, 1, 0, 0, 0, 0, 0, 0, 3));                  // above the limit
      send(tri_from(1, 0, 0, 0, 0, 0, 2, 0, 0));                  // collinear
      send(tri_from(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX));
      send(tri_from(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX));
      send(tri_from(CMAX, 0, 0, CMIN, 0, 0, CMAX, CMAX, CMIN));
      send(tri_from(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMIN));
      send(tri_from(ONE, ONE, 0, 0, 0, 0, 0, ONE, 1));            // tiny x and y, above threshold
      send(tri_from(ONE, 0, 0, 0, 0, 0, 0, ONE, -1));             // mirror, negative tiny
      send(tri_from(3, 0, 0, 0, 0, 0, 0, 4, 0));
      send(tri_from(-ONE, 7, 0, 0, 0, 0, 0, -ONE, 0));
      drain();

      // Unused register index is ignored, then a pass per threshold setting
      csr_write(ADDR_UNUSED, 32'hFFFF_FFFF);
      csr_readback();
      for (int ph = 0; ph < 5; ph++) begin
         csr_write(ADDR_ZERO_THRESHOLD, {16'($urandom), thresholds[ph]});
         csr_readback();
         for (int i = 0; i < 400; i++) begin
            if (i == 200) drain();   // sender holds off until the pipe is empty
            send(random_tri());
         end
         drain();
      end

      if (board.errors == 0) $display("tb_triangle_unit_normal: done, clean");
      else $display("tb_triangle_unit_normal: done, errors");
      $finish;
   end

   initial begin
      #2ms;
      $display("tb_triangle_unit_normal: done, errors");
      $finish;
   end

endmodule

// ===== triangle_unit_normal.f =====
rtl/tun_pkg.sv
rtl/triangle_unit_normal.sv
rtl/tun_chk.sv
bench/tb_triangle_unit_normal.sv
